FILE: hw/rtl/extent_request_splitter_core_assert.svh
// Assertion macros for the extent request splitter.
// Used by modules that carry a clock and a reset signal in scope.
`ifndef EXTENT_REQUEST_SPLITTER_CORE_ASSERT_SVH
`define EXTENT_REQUEST_SPLITTER_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define ERS_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ers: assertion failed");

// next-cycle implication, off during reset
`define ERS_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ers: assertion failed");

`endif

FILE: hw/rtl/ers_pkg.sv
// Shared constants, codes and types of the extent request splitter.
// No dependencies.
package ers_pkg;

   localparam int MAX_EXTENTS  = 16;
   localparam int SECTOR_BYTES = 512;
   localparam int QUEUE_DEPTH  = 2;

   localparam int IDX_W        = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
   localparam int CNT_W        = $clog2(MAX_EXTENTS + 1);
   localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);

   localparam int OPCODE_W   = 1;
   localparam int ENTRY_W    = 4;
   localparam int ADDR_W     = 48;
   localparam int SECTOR_W   = 39;
   localparam int COUNT_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int BYTES_W    = 41;
   localparam int CFG_W      = 5;

   localparam int LOGICAL_W  = SECTOR_W + SECTOR_SHIFT;
   localparam int TOTAL_W    = COUNT_W + SECTOR_SHIFT;
   localparam int STOP_W     = ((LOGICAL_W > ADDR_W) ? LOGICAL_W : ADDR_W) + 1;

   localparam logic [OPCODE_W-1:0] OP_LOAD = 1'b0;
   localparam logic [OPCODE_W-1:0] OP_MAP  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_CLOSED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NODEV  = 2'd2;

   typedef struct packed {
      logic                 is_load;
      logic [ENTRY_W-1:0]   index;
      logic [ADDR_W-1:0]    ext_start;
      logic [ADDR_W-1:0]    ext_end;
      logic [ADDR_W-1:0]    ext_base;
      logic                 ext_open;
      logic [LOGICAL_W-1:0] logical;
      logic [TOTAL_W-1:0]   total;
      logic [STOP_W-1:0]    stop;
      logic                 is_write;
   } queue_entry_type;

   typedef struct packed {
      logic push;
      logic full;
   } queue_push_type;

   typedef struct packed {
      logic valid;
      logic pop;
   } queue_pop_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ENTRY_W-1:0]  extent_index;
      logic [ADDR_W-1:0]   target_offset;
      logic [BYTES_W-1:0]  segment_bytes;
      logic                segment_is_write;
      logic                last_segment;
   } result_type;

endpackage

FILE: hw/rtl/ers_if.sv
// Channel interfaces of the extent request splitter: request, result, csr.
// Depends on ers_pkg.
interface ers_req_if;
   logic                           valid;
   logic                           ready;
   logic [ers_pkg::OPCODE_W-1:0]   opcode;
   logic [ers_pkg::ENTRY_W-1:0]    entry_index;
   logic [ers_pkg::ADDR_W-1:0]     entry_start;
   logic [ers_pkg::ADDR_W-1:0]     entry_end;
   logic [ers_pkg::ADDR_W-1:0]     entry_file_base;
   logic                           entry_open;
   logic [ers_pkg::SECTOR_W-1:0]   start_sector;
   logic [ers_pkg::COUNT_W-1:0]    sector_count;
   logic                           write_request;

   modport source (output valid, opcode, entry_index, entry_start, entry_end,
                   entry_file_base, entry_open, start_sector, sector_count,
                   write_request, input ready);
   modport sink   (input valid, opcode, entry_index, entry_start, entry_end,
                   entry_file_base, entry_open, start_sector, sector_count,
                   write_request, output ready);
endinterface

interface ers_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [ers_pkg::STATUS_W-1:0]   status;
   logic [ers_pkg::ENTRY_W-1:0]    extent_index;
   logic [ers_pkg::ADDR_W-1:0]     target_offset;
   logic [ers_pkg::BYTES_W-1:0]    segment_bytes;
   logic                           segment_is_write;
   logic                           last_segment;

   modport source (output valid, status, extent_index, target_offset, segment_bytes,
                   segment_is_write, last_segment, input ready);
   modport sink   (input valid, status, extent_index, target_offset, segment_bytes,
                   segment_is_write, last_segment, output ready);
endinterface

interface ers_csr_if;
   logic                        valid;
   logic                        ready;
   logic [ers_pkg::CFG_W-1:0]   data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

FILE: hw/rtl/ers_front.sv
// Front end: accepts request-channel beats and decodes them into queue entries.
// Depends on ers_pkg and ers_req_if.
module ers_front (
   ers_req_if.sink                 req_chan,
   input  logic                    q_full,
   output ers_pkg::queue_push_type q_push,
   output ers_pkg::queue_entry_type q_entry
);

   logic [ers_pkg::LOGICAL_W-1:0] logical;
   logic [ers_pkg::TOTAL_W-1:0]   total;

   assign req_chan.ready = !q_full;
   assign q_push.push    = req_chan.valid && !q_full;
   assign q_push.full    = q_full;

   // byte range of the request: sector numbers scaled by the sector size
   assign logical = ers_pkg::LOGICAL_W'(req_chan.start_sector) << ers_pkg::SECTOR_SHIFT;
   assign total   = ers_pkg::TOTAL_W'(req_chan.sector_count) << ers_pkg::SECTOR_SHIFT;

   always_comb begin
      q_entry.is_load   = (req_chan.opcode == ers_pkg::OP_LOAD);
      q_entry.index     = req_chan.entry_index;
      q_entry.ext_start = req_chan.entry_start;
      q_entry.ext_end   = req_chan.entry_end;
      q_entry.ext_base  = req_chan.entry_file_base;
      q_entry.ext_open  = req_chan.entry_open;
      q_entry.logical   = logical;
      q_entry.total     = total;
      q_entry.stop      = ers_pkg::STOP_W'(logical) + ers_pkg::STOP_W'(total);
      q_entry.is_write  = req_chan.write_request;
   end

endmodule

FILE: hw/rtl/ers_queue.sv
// Short FIFO of decoded items between the front end and the back end.
// Depends on ers_pkg.
module ers_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  ers_pkg::queue_push_type  push_ctl,
   input  ers_pkg::queue_entry_type push_entry,
   output logic                     full,
   input  ers_pkg::queue_pop_type   pop_ctl,
   output logic                     valid,
   output ers_pkg::queue_entry_type pop_entry
);

   localparam int PTR_W = (ers_pkg::QUEUE_DEPTH > 1) ? $clog2(ers_pkg::QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(ers_pkg::QUEUE_DEPTH + 1);

   ers_pkg::queue_entry_type slots_ff [ers_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              do_push, do_pop;

   assign full      = (fill_ff == FILL_W'(ers_pkg::QUEUE_DEPTH));
   assign valid     = (fill_ff != '0);
   assign pop_entry = slots_ff[rd_ptr_ff];
   assign do_push   = push_ctl.push && !push_ctl.full;
   assign do_pop    = pop_ctl.pop && pop_ctl.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(ers_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(ers_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: hw/rtl/ers_back.sv
// Back end: extent table, csr register, search/check/emit sequencer, result register.
// Depends on ers_pkg, ers_rsp_if, ers_csr_if and the assertion macro header.
`include "extent_request_splitter_core_assert.svh"

module ers_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  ers_pkg::queue_entry_type q_entry,
   output ers_pkg::queue_pop_type   q_pop,
   ers_csr_if.sink                  csr_chan,
   ers_rsp_if.source                rsp_chan
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SEARCH = 3'd1;
   localparam logic [2:0] ST_CHECK  = 3'd2;
   localparam logic [2:0] ST_EMIT   = 3'd3;

   localparam int CNT_W  = ers_pkg::CNT_W;
   localparam int IDX_W  = ers_pkg::IDX_W;
   localparam int STOP_W = ers_pkg::STOP_W;

   // extent table; start/end/base have no reset, usable flags do
   logic [ers_pkg::ADDR_W-1:0] tbl_start_ff [ers_pkg::MAX_EXTENTS];
   logic [ers_pkg::ADDR_W-1:0] tbl_end_ff   [ers_pkg::MAX_EXTENTS];
   logic [ers_pkg::ADDR_W-1:0] tbl_base_ff  [ers_pkg::MAX_EXTENTS];
   logic [ers_pkg::MAX_EXTENTS-1:0] tbl_usable_ff;

   logic [ers_pkg::CFG_W-1:0]   cfg_ff;
   logic [2:0]                  state_ff, state_in;
   ers_pkg::queue_entry_type    cur_ff, cur_in;
   logic [CNT_W-1:0]            limit_ff, limit_in;
   logic [CNT_W-1:0]            k_ff, k_in;
   logic [CNT_W-1:0]            first_ff, first_in;
   logic [CNT_W-1:0]            last_ff, last_in;
   logic [ers_pkg::TOTAL_W-1:0] remain_ff, remain_in;

   logic                        rsp_valid_ff;
   ers_pkg::result_type         rsp_ff;
   ers_pkg::result_type         out_next;
   logic                        out_want, out_free, out_load;

   logic                        tbl_we;
   logic [IDX_W-1:0]            kx, wx;
   logic [ers_pkg::ADDR_W-1:0]  rd_start, rd_end, rd_base, off_first;
   logic                        rd_usable, in_range;
   logic [STOP_W-1:0]           end_x, start_x, logical_x, remain_x, avail, count;

   assign csr_chan.ready = 1'b1;

   assign kx        = k_ff[IDX_W-1:0];
   assign wx        = IDX_W'(q_entry.index);
   assign rd_start  = tbl_start_ff[kx];
   assign rd_end    = tbl_end_ff[kx];
   assign rd_base   = tbl_base_ff[kx];
   assign rd_usable = tbl_usable_ff[kx];
   assign in_range  = (k_ff < limit_ff);

   assign end_x     = STOP_W'(rd_end);
   assign start_x   = STOP_W'(rd_start);
   assign logical_x = STOP_W'(cur_ff.logical);
   assign remain_x  = STOP_W'(remain_ff);
   // file offset for the extent holding the start; wraps at 48 bits
   assign off_first = rd_base + ers_pkg::ADDR_W'(cur_ff.logical) - rd_start;

   always_comb begin
      if (k_ff == first_ff) begin
         avail = end_x - logical_x;
      end else if (end_x > start_x) begin
         avail = end_x - start_x;
      end else begin
         avail = '0;
      end
      count = (remain_x < avail) ? remain_x : avail;
   end

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign out_load = out_want && out_free;

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      limit_in  = limit_ff;
      k_in      = k_ff;
      first_in  = first_ff;
      last_in   = last_ff;
      remain_in = remain_ff;
      q_pop     = '{valid: q_valid, pop: 1'b0};
      tbl_we    = 1'b0;
      out_want  = 1'b0;
      out_next  = '{status: ers_pkg::STATUS_OK, extent_index: '0, target_offset: '0,
                    segment_bytes: '0, segment_is_write: cur_ff.is_write,
                    last_segment: 1'b1};
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop.pop = 1'b1;
               if (q_entry.is_load) begin
                  tbl_we = (32'(q_entry.index) < 32'(ers_pkg::MAX_EXTENTS));
               end else begin
                  cur_in   = q_entry;
                  limit_in = (32'(cfg_ff) > 32'(ers_pkg::MAX_EXTENTS)) ?
                             CNT_W'(ers_pkg::MAX_EXTENTS) : CNT_W'(cfg_ff);
                  k_in     = '0;
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (!in_range) begin
               out_want        = 1'b1;
               out_next.status = ers_pkg::STATUS_NODEV;
               if (out_free) state_in = ST_IDLE;
            end else if (end_x > logical_x) begin
               if (!rd_usable) begin
                  out_want        = 1'b1;
                  out_next.status = ers_pkg::STATUS_CLOSED;
                  if (out_free) state_in = ST_IDLE;
               end else if (end_x >= cur_ff.stop) begin
                  // whole request inside one extent
                  out_want               = 1'b1;
                  out_next.extent_index  = ers_pkg::ENTRY_W'(k_ff);
                  out_next.target_offset = off_first;
                  out_next.segment_bytes = ers_pkg::BYTES_W'(cur_ff.total);
                  if (out_free) state_in = ST_IDLE;
               end else begin
                  first_in = k_ff;
                  k_in     = k_ff + 1'b1;
                  state_in = ST_CHECK;
               end
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_CHECK: begin
            if (in_range && start_x < cur_ff.stop) begin
               if (!rd_usable) begin
                  out_want        = 1'b1;
                  out_next.status = ers_pkg::STATUS_CLOSED;
                  if (out_free) state_in = ST_IDLE;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end else begin
               last_in   = k_ff - 1'b1;
               k_in      = first_ff;
               remain_in = cur_ff.total;
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            out_want               = 1'b1;
            out_next.extent_index  = ers_pkg::ENTRY_W'(k_ff);
            out_next.target_offset = (k_ff == first_ff) ? off_first : rd_base;
            out_next.segment_bytes = ers_pkg::BYTES_W'(count);
            out_next.last_segment  = (k_ff == last_ff);
            if (out_free) begin
               remain_in = remain_ff - ers_pkg::TOTAL_W'(count);
               k_in      = k_ff + 1'b1;
               if (k_ff == last_ff) state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cfg_ff        <= '0;
         tbl_usable_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_chan.valid) begin
            cfg_ff <= csr_chan.data;
         end
         if (tbl_we) begin
            tbl_usable_ff[wx] <= q_entry.ext_open;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      limit_ff  <= limit_in;
      k_ff      <= k_in;
      first_ff  <= first_in;
      last_ff   <= last_in;
      remain_ff <= remain_in;
      if (tbl_we) begin
         tbl_start_ff[wx] <= q_entry.ext_start;
         tbl_end_ff[wx]   <= q_entry.ext_end;
         tbl_base_ff[wx]  <= q_entry.ext_base;
      end
      if (out_load) begin
         rsp_ff <= out_next;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.status           = rsp_ff.status;
   assign rsp_chan.extent_index     = rsp_ff.extent_index;
   assign rsp_chan.target_offset    = rsp_ff.target_offset;
   assign rsp_chan.segment_bytes    = rsp_ff.segment_bytes;
   assign rsp_chan.segment_is_write = rsp_ff.segment_is_write;
   assign rsp_chan.last_segment     = rsp_ff.last_segment;

   `ERS_ASSERT_IMP(a_pop_only_idle, q_pop.pop, state_ff == ST_IDLE)
   `ERS_ASSERT_IMP(a_error_is_last, rsp_valid_ff && rsp_ff.status != ers_pkg::STATUS_OK, rsp_ff.last_segment)
   `ERS_ASSERT_NXT(a_last_ends_item, out_load && out_next.last_segment, state_ff == ST_IDLE)
   `ERS_ASSERT_IMP(a_emit_in_range, state_ff == ST_EMIT, k_ff <= last_ff && k_ff < limit_ff)

endmodule

FILE: hw/rtl/extent_request_splitter_core.sv
// Top level of the extent request splitter: front end, queue, back end.
// Depends on ers_pkg, ers_if, ers_front, ers_queue and ers_back.
//
//  channel   | dir | beat
//  ----------+-----+-------------------------------------------------------
//  req_chan  | in  | load one extent table entry, or map one request
//  rsp_chan  | out | one segment, a closed-extent error or a no-device error
//  csr_chan  | in  | number of table entries in use (5 bits), always ready
//
// A load beat is written to the table as it is dequeued. A request is dequeued, then
// the back end scans entries up to the extent holding the start, checks the open flag
// of each later covered extent, then emits one segment per covered extent.
// The front end keeps taking beats into a two-entry queue while the back end works;
// a full queue drops req_chan.ready, a held rsp_chan stalls the back end in place.
// Synchronous reset clears entry count, open flags, state, queue fill and rsp valid.
module extent_request_splitter_core (
   input logic         clock,
   input logic         reset,
   ers_req_if.sink     req_chan,
   ers_rsp_if.source   rsp_chan,
   ers_csr_if.sink     csr_chan
);

   ers_pkg::queue_push_type  push_ctl;
   ers_pkg::queue_pop_type   pop_ctl;
   ers_pkg::queue_entry_type push_entry;
   ers_pkg::queue_entry_type pop_entry;
   logic                     q_full;
   logic                     q_valid;

   ers_front u_front (
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (push_ctl),
      .q_entry  (push_entry)
   );

   ers_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_ctl   (push_ctl),
      .push_entry (push_entry),
      .full       (q_full),
      .pop_ctl    (pop_ctl),
      .valid      (q_valid),
      .pop_entry  (pop_entry)
   );

   ers_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_entry  (pop_entry),
      .q_pop    (pop_ctl),
      .csr_chan (csr_chan),
      .rsp_chan (rsp_chan)
   );

endmodule
